// ----- src/mmls_pkg.sv -----
// ----------------------------------------------------------------------------
// mmls_pkg
// Shared types, codes and the log threshold table of the min/max log stretch.
// ----------------------------------------------------------------------------
package mmls_pkg;

  localparam int GRAY_BITS = 8;
  localparam int THR_BITS  = 24;          // unsigned 8.16
  localparam int GRAY_TOP  = 254;
  localparam int FX_FRAC   = 52;
  localparam int WORD_BITS = 16;

  typedef enum logic {
    FUNC_MEASURE = 1'b0,
    FUNC_CONVERT = 1'b1
  } func_t;

  typedef logic [THR_BITS-1:0] thr_t;
  typedef logic [GRAY_TOP-1:0][THR_BITS-1:0] thr_tab_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;   // input word taken this cycle
    logic setup;    // clip tests, search init
    logic mul;      // threshold times span
    logic cmp;      // compare, update gray code
    logic put;      // load output register
  } mmls_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic convert;  // func of the word on the input port
    logic clip;     // result settled by the clip tests
    logic bit_last; // last search step
  } mmls_status_t;

  localparam logic [63:0] FX_ONE  = 64'd1 << FX_FRAC;
  localparam logic [63:0] FX_STEP = (64'd1000 << FX_FRAC) / 64'd45986;

  function automatic logic [63:0] fx_mul(input logic [63:0] u, input logic [63:0] v);
    logic [127:0] p;
    p = {64'd0, u} * {64'd0, v};
    return p[FX_FRAC+63:FX_FRAC];
  endfunction

  // T_k = exp(k/45.986) - 1, k = 1..254, rounded to 8.16
  function automatic thr_tab_t mmls_thr_table();
    thr_tab_t    t;
    logic [63:0] q;
    logic [63:0] term;
    logic [63:0] p;
    logic [63:0] r;
    q    = FX_ONE;
    term = FX_ONE;
    p    = FX_ONE;
    // Taylor series of exp(1/45.986), fourteen terms
    term = fx_mul(term, FX_STEP) / 64'd1;  q = q + term;
    term = fx_mul(term, FX_STEP) / 64'd2;  q = q + term;
    term = fx_mul(term, FX_STEP) / 64'd3;  q = q + term;
    term = fx_mul(term, FX_STEP) / 64'd4;  q = q + term;
    term = fx_mul(term, FX_STEP) / 64'd5;  q = q + term;
    term = fx_mul(term, FX_STEP) / 64'd6;  q = q + term;
    term = fx_mul(term, FX_STEP) / 64'd7;  q = q + term;
    term = fx_mul(term, FX_STEP) / 64'd8;  q = q + term;
    term = fx_mul(term, FX_STEP) / 64'd9;  q = q + term;
    term = fx_mul(term, FX_STEP) / 64'd10; q = q + term;
    term = fx_mul(term, FX_STEP) / 64'd11; q = q + term;
    term = fx_mul(term, FX_STEP) / 64'd12; q = q + term;
    term = fx_mul(term, FX_STEP) / 64'd13; q = q + term;
    term = fx_mul(term, FX_STEP) / 64'd14; q = q + term;
    for (int k = 0; k < GRAY_TOP; k++) begin
      p = fx_mul(p, q);
      r = ((p - FX_ONE) + (64'd1 << (FX_FRAC - 17))) >> (FX_FRAC - 16);
      t[k] = r[THR_BITS-1:0];
    end
    return t;
  endfunction

endpackage

// ----- src/mmls_if.sv -----
// ----------------------------------------------------------------------------
// mmls_if
// Valid/ready channels: pixel words in, gray words out.
// ----------------------------------------------------------------------------
interface mmls_pix_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic        first_of_frame;
  logic [15:0] pixel;

  modport source (output valid, output func, output first_of_frame, output pixel,
                  input ready);
  modport sink   (input valid, input func, input first_of_frame, input pixel,
                  output ready);
endinterface

interface mmls_gray_if;
  logic       valid;
  logic       ready;
  logic [7:0] gray_level;

  modport source (output valid, output gray_level, input ready);
  modport sink   (input valid, input gray_level, output ready);
endinterface

// ----- src/minmax_log_stretch_to_gray.sv -----
// ----------------------------------------------------------------------------
// minmax_log_stretch_to_gray
// Min/max logarithmic contrast stretch of 16-bit pixels to gray bytes.
// ----------------------------------------------------------------------------
// Stream each frame twice: measure words (func 0) update the frame min/max when
// accepted, and first_of_frame restarts them. Convert words (func 1) return
// one gray byte, floor(45.986*ln(1+255*(x-min)/(max-min))), 254 at or above
// max, 0 at or below min. A clipped convert goes from setup straight to the put
// state; any other first runs an 8-step binary search over 254 log thresholds,
// where each step passes through the threshold-by-span multiplier and then the
// compare. One word is worked at a time; the output register lets the next word
// in while a result waits.
module minmax_log_stretch_to_gray #(
  parameter int PIXEL_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  mmls_pix_if.sink     pix_in,
  mmls_gray_if.source  gray_out
);
  import mmls_pkg::*;

  mmls_cmd_t    cmd;
  mmls_status_t status;

  mmls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pix_in.valid),
    .in_ready  (pix_in.ready),
    .out_valid (gray_out.valid),
    .out_ready (gray_out.ready),
    .status    (status),
    .cmd       (cmd)
  );

  mmls_dp #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_dp (
    .clk            (clk),
    .func           (pix_in.func),
    .first_of_frame (pix_in.first_of_frame),
    .pixel          (pix_in.pixel),
    .cmd            (cmd),
    .status         (status),
    .gray_level     (gray_out.gray_level),
    .rst            (rst)
  );

endmodule

// ----- src/mmls_dp.sv -----
// ----------------------------------------------------------------------------
// mmls_dp
// Datapath: frame min/max, clip tests, binary threshold search, output data.
// ----------------------------------------------------------------------------
module mmls_dp #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 func,
  input  logic                                 first_of_frame,
  input  logic [mmls_pkg::WORD_BITS-1:0]       pixel,
  input  mmls_pkg::mmls_cmd_t                  cmd,
  output mmls_pkg::mmls_status_t               status,
  output logic [mmls_pkg::GRAY_BITS-1:0]       gray_level,
  input  logic                                 rst
);
  import mmls_pkg::*;

  localparam int PB = PIXEL_BITS;
  localparam int NB = PB + THR_BITS;
  localparam thr_tab_t THR = mmls_thr_table();
  localparam logic [GRAY_BITS-1:0] GRAY_MAX = GRAY_BITS'(GRAY_TOP);

  logic [PB-1:0]        x_in;
  logic [PB-1:0]        x;
  logic [PB-1:0]        frame_min;
  logic [PB-1:0]        frame_max;
  logic [PB-1:0]        diff;
  logic [PB-1:0]        span;
  logic [PB+7:0]        diff255;
  logic [NB-1:0]        num;
  logic [NB-1:0]        prod;
  logic [NB-1:0]        prod_next;
  logic [GRAY_BITS-1:0] g;
  logic [GRAY_BITS-1:0] cand;
  logic [GRAY_BITS-1:0] cand_next;
  logic [GRAY_BITS-1:0] idx;
  logic                 cand_ok;
  logic                 cand_ok_next;
  logic [2:0]           bitpos;
  logic                 clip_hi;
  logic                 clip_lo;

  assign x_in    = pixel[PB-1:0];
  assign clip_hi = (x >= frame_max);
  assign clip_lo = (x <= frame_min);

  assign status.convert  = (func == FUNC_CONVERT);
  assign status.clip     = clip_hi | clip_lo;
  assign status.bit_last = (bitpos == 3'd0);

  // 255 * (x - min), placed over 16 fraction bits
  assign diff255 = {diff, 8'd0} - {8'd0, diff};
  assign num     = {diff255, 16'd0};

  assign cand_next    = g | (GRAY_BITS'(1) << bitpos);
  assign cand_ok_next = (cand_next <= GRAY_MAX);
  assign idx          = cand_ok_next ? (cand_next - GRAY_BITS'(1)) : '0;
  assign prod_next    = {{PB{1'b0}}, THR[idx]} * {{THR_BITS{1'b0}}, span};

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_min <= '1;
      frame_max <= '0;
    end else if (cmd.accept && func == FUNC_MEASURE) begin
      if (first_of_frame) begin
        frame_min <= x_in;
        frame_max <= x_in;
      end else begin
        if (x_in < frame_min) frame_min <= x_in;
        if (x_in > frame_max) frame_max <= x_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) x <= x_in;
    if (cmd.setup) begin
      diff   <= x - frame_min;
      span   <= frame_max - frame_min;
      g      <= clip_hi ? GRAY_MAX : '0;
      bitpos <= 3'd7;
    end
    if (cmd.mul) begin
      prod    <= prod_next;
      cand    <= cand_next;
      cand_ok <= cand_ok_next;
    end
    if (cmd.cmp) begin
      if (cand_ok && num >= prod) g <= cand;
      bitpos <= bitpos - 3'd1;
    end
    if (cmd.put) gray_level <= g;
  end

endmodule

// ----- src/mmls_ctrl.sv -----
// ----------------------------------------------------------------------------
// mmls_ctrl
// Controller: input handshake, search sequencing, output valid.
// ----------------------------------------------------------------------------
module mmls_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  mmls_pkg::mmls_status_t status,
  output mmls_pkg::mmls_cmd_t    cmd
);
  import mmls_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_MUL,
    S_CMP,
    S_PUT
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    cmd.accept = in_valid && in_ready;
    unique case (state)
      S_IDLE: begin
        if (cmd.accept && status.convert) state_next = S_SETUP;
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = status.clip ? S_PUT : S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = status.bit_last ? S_PUT : S_MUL;
      end
      S_PUT: begin
        if (out_free) begin
          cmd.put    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.put)        out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- src/mmls_checker.sv -----
// ----------------------------------------------------------------------------
// mmls_checker
// Port-level checks of the min/max log stretch, bound to the top level.
// ----------------------------------------------------------------------------
module mmls_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_func,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] gray_level
);
  import mmls_pkg::*;

  a_gray_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> gray_level <= 8'(GRAY_TOP))
    else $error("gray word above top code");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(gray_level))
    else $error("stalled gray word changed");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("gray word valid after reset");

  a_measure_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_func == FUNC_MEASURE && !out_valid |=> !out_valid)
    else $error("measure word produced a gray word");

  a_convert_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_func == FUNC_CONVERT |=> !in_ready)
    else $error("input open during convert");

endmodule

bind minmax_log_stretch_to_gray mmls_checker u_mmls_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (pix_in.valid),
  .in_ready   (pix_in.ready),
  .in_func    (pix_in.func),
  .out_valid  (gray_out.valid),
  .out_ready  (gray_out.ready),
  .gray_level (gray_out.gray_level)
);

// ----- verif/tb_minmax_log_stretch_to_gray.sv -----
// ----------------------------------------------------------------------------
// tb_minmax_log_stretch_to_gray
// Self-checking bench for the min/max log contrast stretch.
// ----------------------------------------------------------------------------
// Frames go in twice: first as measure words that set the frame min/max, then
// as convert words whose gray bytes are predicted and compared in order. The
// random part mixes well-formed frames, frames with no restart flag, and loose
// noise words. Both channels idle at random, with one stretch of no idling.
// ----------------------------------------------------------------------------
module tb_minmax_log_stretch_to_gray;
  timeunit 1ns;
  timeprecision 1ps;

  import mmls_pkg::*;

  localparam int RANDOM_WORDS = 1450;
  localparam int WATCHDOG     = 3000;
  localparam int TAIL_CYCLES  = 40;

  typedef enum logic [1:0] {PX_ANY, PX_NARROW, PX_FLAT, PX_EDGE} px_mode_t;

  // Predicts gray bytes from the running frame min/max and holds them in order.
  class stretch_scoreboard;
    logic [15:0] lo_px;
    logic [15:0] hi_px;
    logic [23:0] knee [GRAY_TOP];
    logic [7:0]  gray_due [$];
    int          n_bad;

    function new();
      lo_px = 16'hFFFF;
      hi_px = 16'h0000;
      n_bad = 0;
      build_knees();
    endfunction

    // product of two unsigned 12.52 numbers
    function logic [63:0] mul_q52(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] full;
      full = {64'd0, a} * {64'd0, b};
      return full[115:52];
    endfunction

    // knee[k] = exp((k+1)/45.986) - 1 in 8.16, round half up
    function void build_knees();
      logic [63:0] unit;
      logic [63:0] inc;
      logic [63:0] growth;
      logic [63:0] term;
      logic [63:0] acc;
      logic [63:0] r;
      unit   = 64'd1 << 52;
      inc    = (64'd1000 << 52) / 64'd45986;
      growth = unit;
      term   = unit;
      for (int n = 1; n <= 14; n++) begin
        term   = mul_q52(term, inc) / 64'(n);
        growth = growth + term;
      end
      acc = unit;
      for (int k = 0; k < GRAY_TOP; k++) begin
        acc     = mul_q52(acc, growth);
        r       = ((acc - unit) + (64'd1 << 35)) >> 36;
        knee[k] = r[23:0];
      end
    endfunction

    function logic [7:0] stretch(input logic [15:0] px);
      logic [63:0] num;
      logic [63:0] span;
      int          g;
      if (px >= hi_px) return 8'(GRAY_TOP);
      if (px <= lo_px) return 8'd0;
      num  = (64'(px - lo_px) * 64'd255) << 16;
      span = 64'(hi_px - lo_px);
      g    = 0;
      for (int k = 0; k < GRAY_TOP; k++) begin
        if (num >= 64'(knee[k]) * span) g = k + 1;
        else break;
      end
      return 8'(g);
    endfunction

    function void take_pixel(input func_t f, input logic first, input logic [15:0] px);
      if (f == FUNC_MEASURE) begin
        if (first) begin
          lo_px = px;
          hi_px = px;
        end else begin
          if (px < lo_px) lo_px = px;
          if (px > hi_px) hi_px = px;
        end
      end else begin
        gray_due.push_back(stretch(px));
      end
    endfunction

    function void check_gray(input logic [7:0] got);
      logic [7:0] want;
      if (gray_due.size() == 0) begin
        $error("gray_level: expected none, actual %0d", got);
        n_bad++;
      end else begin
        want = gray_due.pop_front();
        if (got !== want) begin
          $error("gray_level: expected %0d, actual %0d", want, got);
          n_bad++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic calm = 1'b0;
  int   words_sent = 0;
  int   stall_cycles = 0;

  stretch_scoreboard sb;

  mmls_pix_if  pix ();
  mmls_gray_if gray ();

  minmax_log_stretch_to_gray uut (
    .clk      (clk),
    .rst      (rst),
    .pix_in   (pix),
    .gray_out (gray)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    gray.ready <= calm || ($urandom_range(0, 99) >= 16);
  end

  always @(posedge clk) begin
    if (!rst && gray.valid && gray.ready) sb.check_gray(gray.gray_level);
  end

  // ends the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (pix.valid && pix.ready) || (gray.valid && gray.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_word(input func_t f, input logic first, input logic [15:0] px);
    calm = (words_sent >= 600) && (words_sent < 800);
    while (!calm && $urandom_range(0, 99) < 16) begin
      pix.valid <= 1'b0;
      @(posedge clk);
    end
    pix.valid          <= 1'b1;
    pix.func           <= f;
    pix.first_of_frame <= first;
    pix.pixel          <= px;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
    sb.take_pixel(f, first, px);
    words_sent++;
  endtask

  task automatic wait_drained();
    pix.valid <= 1'b0;
    do @(posedge clk); while (sb.gray_due.size() != 0);
  endtask

  function automatic logic [15:0] pick_pixel(input px_mode_t mode, input logic [15:0] base,
                                             input int spread);
    logic [16:0] sum;
    case (mode)
      PX_FLAT: return base;
      PX_NARROW: begin
        sum = 17'(base) + 17'($urandom_range(0, spread));
        return sum[16] ? 16'hFFFF : sum[15:0];
      end
      PX_EDGE: begin
        case ($urandom_range(0, 4))
          0: return 16'h0000;
          1: return 16'h0001;
          2: return 16'hFFFE;
          3: return 16'hFFFF;
          default: return 16'($urandom);
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    px_mode_t    mode;
    logic [15:0] base;
    logic [15:0] px;
    logic [15:0] shot [$];
    int          spread;
    int          n;
    int          m;
    logic        broken;

    sb = new();
    rst                <= 1'b1;
    pix.valid          <= 1'b0;
    pix.func           <= FUNC_MEASURE;
    pix.first_of_frame <= 1'b0;
    pix.pixel          <= 16'h0000;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // convert before any measure: max is still 0
    send_word(FUNC_CONVERT, 1'b0, 16'h0000);
    send_word(FUNC_CONVERT, 1'b0, 16'hFFFF);
    // flat frame: min equals max
    send_word(FUNC_MEASURE, 1'b1, 16'd1000);
    send_word(FUNC_CONVERT, 1'b0, 16'd1000);
    send_word(FUNC_CONVERT, 1'b0, 16'd999);
    send_word(FUNC_CONVERT, 1'b0, 16'd1001);
    // full-range frame
    send_word(FUNC_MEASURE, 1'b1, 16'h0000);
    send_word(FUNC_MEASURE, 1'b0, 16'hFFFF);
    send_word(FUNC_CONVERT, 1'b0, 16'h0000);
    send_word(FUNC_CONVERT, 1'b0, 16'hFFFF);
    send_word(FUNC_CONVERT, 1'b0, 16'h0001);
    send_word(FUNC_CONVERT, 1'b0, 16'h8000);
    send_word(FUNC_CONVERT, 1'b0, 16'hFFFE);
    send_word(FUNC_CONVERT, 1'b0, 16'hAAAA);
    send_word(FUNC_CONVERT, 1'b0, 16'h5555);
    // restart flag on a convert word is ignored
    send_word(FUNC_CONVERT, 1'b1, 16'd100);
    // narrow frame, interior points
    send_word(FUNC_MEASURE, 1'b1, 16'd100);
    send_word(FUNC_MEASURE, 1'b0, 16'd200);
    send_word(FUNC_CONVERT, 1'b0, 16'd150);
    send_word(FUNC_CONVERT, 1'b0, 16'd101);
    send_word(FUNC_CONVERT, 1'b0, 16'd199);
    wait_drained();

    while (words_sent < RANDOM_WORDS + 21) begin
      if ($urandom_range(0, 9) == 0) begin
        // loose noise words
        repeat ($urandom_range(1, 6))
          send_word(func_t'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 16'($urandom));
      end else begin
        n      = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
        mode   = px_mode_t'($urandom_range(0, 3));
        base   = 16'($urandom);
        spread = ($urandom_range(0, 3) == 0) ? $urandom_range(256, 65535)
                                             : $urandom_range(1, 255);
        broken = ($urandom_range(0, 9) == 0);
        shot.delete();
        for (int i = 0; i < n; i++) shot.push_back(pick_pixel(mode, base, spread));
        for (int i = 0; i < n; i++) send_word(FUNC_MEASURE, (i == 0) && !broken, shot[i]);
        m = n + $urandom_range(0, 3);
        for (int j = 0; j < m; j++) begin
          if (j < n && $urandom_range(0, 3) != 0) px = shot[$urandom_range(0, n - 1)];
          else if ($urandom_range(0, 1) == 1) px = pick_pixel(mode, base, spread);
          else px = 16'($urandom);
          send_word(FUNC_CONVERT, 1'($urandom_range(0, 1)), px);
        end
      end
      if ($urandom_range(0, 19) == 0) wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.gray_due.size() != 0) begin
      $error("gray_level: expected %0d more words, actual none", sb.gray_due.size());
      sb.n_bad++;
    end
    if (sb.n_bad == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
